### design/multi_pattern_byte_replacer_core_assert.svh
// Assertion macros for the multi-pattern byte replacer checker.
// Used by the checker module only.
`ifndef MULTI_PATTERN_BYTE_REPLACER_CORE_ASSERT_SVH
`define MULTI_PATTERN_BYTE_REPLACER_CORE_ASSERT_SVH
// implication check, reset gated
`define MPBR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication check, reset gated
`define MPBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### design/mpbr_pkg.sv
// Package for the multi-pattern byte replacer: sizes, types, states.
// No dependencies.
`default_nettype none
package mpbr_pkg;
   localparam int NUM_PATTERNS_DEF = 8;
   localparam int MAX_LEN_DEF = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [0:0] {
      KIND_DATA  = 1'b0,
      KIND_TABLE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_EMIT   = 2'd2
   } back_state_type;
endpackage
`default_nettype wire

### design/mpbr_if.sv
// Valid/ready channel interfaces for request, response and csr.
// No dependencies.
`default_nettype none
interface mpbr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic       last;
   logic [2:0] pattern_index;
   logic [3:0] pattern_pos;
   logic [7:0] search_byte;
   logic [7:0] replace_byte;
   logic [4:0] pattern_length;
   modport source (output valid, kind, data_byte, last, pattern_index, pattern_pos,
      search_byte, replace_byte, pattern_length, input ready);
   modport sink (input valid, kind, data_byte, last, pattern_index, pattern_pos,
      search_byte, replace_byte, pattern_length, output ready);
endinterface

interface mpbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        replaced;
   logic        out_last;
   logic [31:0] patch_count;
   modport source (output valid, out_byte, replaced, out_last, patch_count, input ready);
   modport sink (input valid, out_byte, replaced, out_last, patch_count, output ready);
endinterface

interface mpbr_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] active_patterns;
   modport source (output valid, active_patterns, input ready);
   modport sink (input valid, active_patterns, output ready);
endinterface
`default_nettype wire

### design/mpbr_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module mpbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### design/mpbr_front.sv
// Front end: accepts requests and pushes them into a short queue.
// Depends on mpbr_pkg.
`default_nettype none
module mpbr_front import mpbr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mpbr_req_if.sink    req,
   input  wire logic   pop,
   output logic        q_valid,
   output logic [37:0] q_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   logic [37:0]   q_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          push;

   assign req.ready = (cnt_ff != (AW+1)'(DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= {req.kind, req.data_byte, req.last, req.pattern_index,
            req.pattern_pos, req.search_byte, req.replace_byte, req.pattern_length};
      end
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule
`default_nettype wire

### design/mpbr_back.sv
// Back end: pattern tables, lookahead window, match search and output.
// Depends on mpbr_pkg and mpbr_ram.
`default_nettype none
module mpbr_back import mpbr_pkg::*; #(
   parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   q_valid,
   input  wire logic [37:0] q_data,
   output logic        pop,
   input  wire logic [3:0] active_patterns,
   mpbr_rsp_if.source  rsp
);
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int IW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int TD = NUM_PATTERNS * MAX_LEN;
   localparam int TW = $clog2(TD) > 0 ? $clog2(TD) : 1;

   logic       q_kind, q_last;
   logic [7:0] q_byte, q_sb, q_rb;
   logic [2:0] q_idx;
   logic [3:0] q_pos;
   logic [4:0] q_len;
   assign {q_kind, q_byte, q_last, q_idx, q_pos, q_sb, q_rb, q_len} = q_data;

   back_state_type state_ff, state_in;
   logic [7:0]    win_ff [MAX_LEN];
   logic [LW-1:0] fill_ff, fill_in;
   logic [LW-1:0] len_ff [NUM_PATTERNS];
   logic [31:0]   cnt_ff, cnt_in;
   logic          flush_ff, flush_in;
   logic [IW:0]   pi_ff, pi_in;           // pattern under test
   logic [PW:0]   bj_ff, bj_in;           // byte under test
   logic          ok_ff, ok_in;
   logic          best_v_ff, best_v_in;
   logic [IW-1:0] best_ff, best_in;
   logic [LW-1:0] blen_ff, blen_in;
   logic          rd_pend_ff, rd_pend_in; // table read in flight
   logic [PW:0]   ej_ff, ej_in;           // emit position
   logic [LW-1:0] drop;
   logic          do_drop;
   logic [IW:0]   act;
   logic          tbl_we;
   logic [TW-1:0] rd_addr, wr_addr;
   logic [7:0]    s_rd, r_rd;
   logic [LW-1:0] cur_len;
   logic [LW-1:0] w_len;

   assign act = (active_patterns > 4'(NUM_PATTERNS)) ? (IW+1)'(NUM_PATTERNS)
      : (IW+1)'(active_patterns);
   assign tbl_we = (state_ff == ST_IDLE) && q_valid && (q_kind == KIND_TABLE)
      && ({1'b0, q_idx} < 4'(NUM_PATTERNS)) && ({1'b0, q_pos} < 5'(MAX_LEN));
   assign wr_addr = TW'(q_idx) * TW'(MAX_LEN) + TW'(q_pos);
   assign w_len = (q_len > 5'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(q_len);
   assign cur_len = len_ff[pi_ff[IW-1:0]];

   mpbr_ram #(.WIDTH(8), .DEPTH(TD)) u_search (.clock(clock), .wr_en(tbl_we),
      .wr_addr(wr_addr), .wr_data(q_sb), .rd_addr(rd_addr), .rd_data(s_rd));
   mpbr_ram #(.WIDTH(8), .DEPTH(TD)) u_replace (.clock(clock), .wr_en(tbl_we),
      .wr_addr(wr_addr), .wr_data(q_rb), .rd_addr(rd_addr), .rd_data(r_rd));

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; cnt_in = cnt_ff; flush_in = flush_ff;
      pi_in = pi_ff; bj_in = bj_ff; ok_in = ok_ff; best_v_in = best_v_ff;
      best_in = best_ff; blen_in = blen_ff; rd_pend_in = 1'b0; ej_in = ej_ff;
      pop = 1'b0; do_drop = 1'b0; drop = '0;
      rsp.valid = 1'b0; rsp.out_byte = win_ff[0]; rsp.replaced = 1'b0;
      rsp.out_last = 1'b0; rsp.patch_count = '0;
      rd_addr = TW'(pi_ff[IW-1:0]) * TW'(MAX_LEN) + TW'(bj_ff[PW-1:0]);
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               if (q_kind == KIND_DATA) begin
                  if (fill_ff < LW'(MAX_LEN)) fill_in = fill_ff + 1'b1;
                  flush_in = q_last;
                  if (q_last || (fill_ff + 1'b1 >= LW'(MAX_LEN))) begin
                     state_in = ST_SEARCH;
                     pi_in = '0; bj_in = '0; ok_in = 1'b1; best_v_in = 1'b0;
                  end
               end
            end
         end
         ST_SEARCH: begin
            if (pi_ff >= act) begin
               state_in = ST_EMIT; ej_in = '0; rd_pend_in = 1'b0;
               bj_in = '0; pi_in = (IW+1)'(best_ff);
            end else if (cur_len == '0 || cur_len > fill_ff
                  || (best_v_ff && cur_len >= blen_ff)
                  || (!rd_pend_ff && !ok_ff)) begin
               pi_in = pi_ff + 1'b1; bj_in = '0; ok_in = 1'b1;
            end else if (!rd_pend_ff) begin
               rd_pend_in = 1'b1;
            end else begin
               if (s_rd != win_ff[bj_ff[PW-1:0]]) begin
                  ok_in = 1'b0;
               end else if (bj_ff + 1'b1 == (PW+1)'(cur_len)) begin
                  best_v_in = 1'b1; best_in = pi_ff[IW-1:0]; blen_in = cur_len;
                  ok_in = 1'b0;
               end else begin
                  bj_in = bj_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!best_v_ff) begin
               rsp.valid = 1'b1;
               rsp.out_last = flush_ff && (fill_ff == LW'(1));
               rsp.patch_count = rsp.out_last ? cnt_ff : '0;
               if (rsp.ready) begin
                  do_drop = 1'b1; drop = LW'(1);
               end
            end else if (!rd_pend_ff) begin
               rd_addr = TW'(best_ff) * TW'(MAX_LEN) + TW'(ej_ff[PW-1:0]);
               rd_pend_in = 1'b1;
            end else begin
               rd_addr = TW'(best_ff) * TW'(MAX_LEN) + TW'(ej_ff[PW-1:0]);
               rsp.valid = 1'b1; rsp.out_byte = r_rd; rsp.replaced = 1'b1;
               rsp.out_last = flush_ff && (fill_ff == blen_ff)
                  && (ej_ff + 1'b1 == (PW+1)'(blen_ff));
               rsp.patch_count = rsp.out_last
                  ? ((cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1) : '0;
               rd_pend_in = 1'b1;
               if (rsp.ready) begin
                  rd_pend_in = 1'b0;
                  ej_in = ej_ff + 1'b1;
                  if (ej_ff + 1'b1 == (PW+1)'(blen_ff)) begin
                     do_drop = 1'b1; drop = blen_ff;
                     if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
            if (do_drop) begin
               fill_in = fill_ff - drop;
               if (flush_ff && fill_in != '0) begin
                  state_in = ST_SEARCH;
                  pi_in = '0; bj_in = '0; ok_in = 1'b1; best_v_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
                  if (flush_ff) begin
                     cnt_in = '0; flush_in = 1'b0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_kind == KIND_DATA && fill_ff < LW'(MAX_LEN))
         win_ff[fill_ff[PW-1:0]] <= q_byte;
      if (do_drop) begin
         for (int i = 0; i < MAX_LEN; i++) begin
            if (LW'(i) + drop < LW'(MAX_LEN))
               win_ff[i] <= win_ff[PW'(LW'(i) + drop)];
         end
      end
      pi_ff <= pi_in; bj_ff <= bj_in; ok_ff <= ok_in;
      best_ff <= best_in; blen_ff <= blen_in; ej_ff <= ej_in;
      if (reset) begin
         state_ff <= ST_IDLE; fill_ff <= '0; cnt_ff <= '0; flush_ff <= 1'b0;
         best_v_ff <= 1'b0; rd_pend_ff <= 1'b0;
         for (int k = 0; k < NUM_PATTERNS; k++) len_ff[k] <= '0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; cnt_ff <= cnt_in;
         flush_ff <= flush_in; best_v_ff <= best_v_in; rd_pend_ff <= rd_pend_in;
         if (state_ff == ST_IDLE && q_valid && q_kind == KIND_TABLE
               && {1'b0, q_idx} < 4'(NUM_PATTERNS))
            len_ff[q_idx[IW-1:0]] <= w_len;
      end
   end
endmodule
`default_nettype wire

### design/multi_pattern_byte_replacer_core.sv
// Top level of the multi-pattern byte replacer.
// Depends on mpbr_pkg, the channel interfaces, mpbr_front and mpbr_back.
//
// Usage:
//  req channel carries data bytes (kind 0) and pattern table writes (kind 1).
//  rsp channel returns the patched byte stream; out_last marks the final
//  byte of a buffer and then patch_count holds the saturating patch count.
//  csr channel writes active_patterns; write only while the block is idle.
// Sequencing:
//  The front end queues up to two requests. The back end takes one at a time.
//  A table write or a byte that does not complete the window is taken in
//  IDLE. A decision scans patterns serially through the shared read address
//  of the two pattern RAMs: it skips a pattern, or reads and compares its
//  bytes one at a time and then moves on, closes the scan, then emits each
//  replaced byte after a read of the replace RAM or passes a byte directly.
//  The last byte runs decisions until the window is empty.
// Reset: clears the window fill, lengths, counter and queue; table contents
//  stay undefined until written.
// Stall: rsp.valid holds with stable data until rsp.ready; the queue keeps
//  accepting requests until it is full.
`default_nettype none
module multi_pattern_byte_replacer_core import mpbr_pkg::*; #(
   parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input wire logic clock,
   input wire logic reset,
   mpbr_req_if.sink   req,
   mpbr_rsp_if.source rsp,
   mpbr_csr_if.sink   csr
);
   logic [3:0]  active_ff;
   logic        pop, q_valid;
   logic [37:0] q_data;

   // csr is always ready
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) active_ff <= '0;
      else if (csr.valid) active_ff <= csr.active_patterns;
   end

   mpbr_front u_front (.clock(clock), .reset(reset), .req(req), .pop(pop),
      .q_valid(q_valid), .q_data(q_data));

   mpbr_back #(.NUM_PATTERNS(NUM_PATTERNS), .MAX_LEN(MAX_LEN)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data), .pop(pop),
      .active_patterns(active_ff), .rsp(rsp));
endmodule
`default_nettype wire

### design/mpbr_checker.sv
// Port-level checker for the byte replacer, bound to the top level.
// Depends on multi_pattern_byte_replacer_core_assert.svh.
`default_nettype none
`include "multi_pattern_byte_replacer_core_assert.svh"
module mpbr_core_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_byte,
   input wire logic        rsp_last,
   input wire logic [31:0] rsp_count,
   input wire logic        csr_ready
);
   `MPBR_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MPBR_ASSERT_NEXT(a_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_byte))
   `MPBR_ASSERT_IMP(a_cnt_zero, clock, reset, rsp_valid && !rsp_last, rsp_count == '0)
   `MPBR_ASSERT_IMP(a_csr_rdy, clock, reset, 1'b1, csr_ready)
endmodule

bind multi_pattern_byte_replacer_core mpbr_core_checker u_checker (.clock(clock),
   .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_byte(rsp.out_byte),
   .rsp_last(rsp.out_last), .rsp_count(rsp.patch_count), .csr_ready(csr.ready));
`default_nettype wire
